// ----- rtl/core/satq_pkg.sv -----
package satq_pkg;

  localparam int unsigned ID_W     = 4;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned ENTRY_W  = TICK_W + ID_W;  // {due, id}
  localparam int unsigned MAX_FIRE = 16;             // fired alarms per tick at most
  localparam int unsigned POP_W    = $clog2(MAX_FIRE + 1);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_FIRED     = 3'd0,
    ST_SET_OK    = 3'd1,
    ST_SET_FULL  = 3'd2,
    ST_CLEARED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_CHK,
    S_FIND_RD,
    S_FIND_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_RD,
    S_INS_CHK,
    S_RESP
  } state_e;

  // Logical slot that the RAM read goes to.
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_IDX,
    RD_NEXT,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,  // move read entry into slot idx
    WR_NEW     // place the pending set item into slot idx
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC,
    IDX_FILL,
    IDX_FILL_M1
  } idx_op_e;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC
  } fill_op_e;

  typedef enum logic {
    OUT_PEND,  // fired alarm held from the pop loop
    OUT_RESP   // single set or clear response
  } out_src_e;

  typedef struct packed {
    logic     load_item;
    logic     tick_inc;
    logic     rd_en;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    idx_op_e  idx_op;
    fill_op_e fill_op;
    logic     pop;
    logic     resp_load;
    status_e  resp_code;
    logic     out_load;
    out_src_e out_src;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    due_ok;
    logic    idx_at_fill;
    logic    next_lt_fill;
    logic    idx_zero;
    logic    full;
    logic    id_match;
    logic    due_gt;
    logic    pend_vld;
    logic    out_free;
  } sts_t;

endpackage

// ----- rtl/core/sorted_alarm_timer_queue.sv -----
// Sorted alarm timer queue. A 32-bit tick counter plus up to DEPTH alarms kept
// in due-tick order (equal due ticks fire in the order they were set), held in
// a single-port circular buffer RAM with a head pointer. A tick transfer
// bumps the counter (wrapping mod 2^32) and fires every head alarm whose due
// tick is at or below the new count, at most 16 per tick, one fired result
// per alarm with tlast on the final one; a tick with nothing due gives no
// result. A set transfer inserts an alarm, replacing any queued entry with
// the same id; a new id on a full queue is rejected. A clear transfer removes
// an alarm by id or reports not found. Set and clear give one result each.
// Action code 3 is dropped without a result. Items are worked one at a time
// through a registered RAM read: a tick reads and checks the head alarm once
// per fired alarm and once more to stop; a set or clear reads and checks each
// entry scanned for the id, reads and writes each entry shifted to close the
// gap, reads and checks each entry moved to open the insert slot, then posts
// the result. The next transfer is taken while the last result still waits in
// the output register; the block stalls only when a further result is due.
module sorted_alarm_timer_queue #(
  parameter int unsigned DEPTH = 16  // queue slots, 1 to 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] alarm_id, [35:4] due_tick, [39:36] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] result_id, [35:4] now_tick, [39:36] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast    // last result of this input
);

  satq_pkg::cmd_t cmd;
  satq_pkg::sts_t sts;

  logic [satq_pkg::ID_W-1:0]   out_id;
  logic [satq_pkg::TICK_W-1:0] out_tick;

  // sequencing: idle/accept, pop loop, id scan, gap close, insert walk, response
  satq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_act_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counter, queue pointers, RAM and the output register
  satq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_act_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata[satq_pkg::ENTRY_W-1:0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_id_o     (out_id),
    .out_tick_o   (out_tick),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_tick, out_id};

endmodule

// ----- rtl/core/satq_ram.sv -----
module satq_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr_i,
  input  logic [Width-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr_i,
  output logic [Width-1:0]                      rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/satq_ctrl.sv -----
module satq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_act_i,
  output logic              in_ready_o,
  input  satq_pkg::sts_t    sts_i,
  output satq_pkg::cmd_t    cmd_o
);

  satq_pkg::state_e state_q, state_d;
  logic             accept;
  logic             stall;

  assign in_ready_o = (state_q == satq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign stall      = sts_i.pend_vld && !sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= satq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      satq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_act_i) inside
            satq_pkg::ACT_TICK:                      state_d = satq_pkg::S_TICK_RD;
            satq_pkg::ACT_SET, satq_pkg::ACT_CLEAR:  state_d = satq_pkg::S_FIND_RD;
            default:                                 state_d = satq_pkg::S_IDLE;
          endcase
        end
      end
      satq_pkg::S_TICK_RD:  state_d = satq_pkg::S_TICK_CHK;
      satq_pkg::S_TICK_CHK: begin
        if (!stall) begin
          state_d = sts_i.due_ok ? satq_pkg::S_TICK_RD : satq_pkg::S_IDLE;
        end
      end
      satq_pkg::S_FIND_RD: begin
        if (!sts_i.idx_at_fill) begin
          state_d = satq_pkg::S_FIND_CHK;
        end else if (sts_i.act == satq_pkg::ACT_CLEAR || sts_i.full) begin
          state_d = satq_pkg::S_RESP;
        end else begin
          state_d = satq_pkg::S_INS_RD;
        end
      end
      satq_pkg::S_FIND_CHK: begin
        state_d = sts_i.id_match ? satq_pkg::S_SHIFT_RD : satq_pkg::S_FIND_RD;
      end
      satq_pkg::S_SHIFT_RD: begin
        if (sts_i.next_lt_fill) begin
          state_d = satq_pkg::S_SHIFT_WR;
        end else if (sts_i.act == satq_pkg::ACT_CLEAR) begin
          state_d = satq_pkg::S_RESP;
        end else begin
          state_d = satq_pkg::S_INS_RD;
        end
      end
      satq_pkg::S_SHIFT_WR: state_d = satq_pkg::S_SHIFT_RD;
      satq_pkg::S_INS_RD: begin
        state_d = sts_i.idx_zero ? satq_pkg::S_RESP : satq_pkg::S_INS_CHK;
      end
      satq_pkg::S_INS_CHK: begin
        state_d = sts_i.due_gt ? satq_pkg::S_INS_RD : satq_pkg::S_RESP;
      end
      satq_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          state_d = satq_pkg::S_IDLE;
        end
      end
      default: state_d = satq_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_sel    = satq_pkg::RD_IDX;
    cmd_o.wr_sel    = satq_pkg::WR_NONE;
    cmd_o.idx_op    = satq_pkg::IDX_HOLD;
    cmd_o.fill_op   = satq_pkg::FILL_HOLD;
    cmd_o.resp_code = satq_pkg::ST_SET_OK;
    cmd_o.out_src   = satq_pkg::OUT_RESP;
    unique case (state_q)
      satq_pkg::S_IDLE: begin
        cmd_o.load_item = accept;
        cmd_o.tick_inc  = accept && (in_act_i == satq_pkg::ACT_TICK);
      end
      satq_pkg::S_TICK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = satq_pkg::RD_HEAD;
      end
      satq_pkg::S_TICK_CHK: begin
        if (!stall) begin
          cmd_o.out_load = sts_i.pend_vld;
          cmd_o.out_src  = satq_pkg::OUT_PEND;
          cmd_o.out_last = !sts_i.due_ok;
          cmd_o.pop      = sts_i.due_ok;
        end
      end
      satq_pkg::S_FIND_RD: begin
        if (!sts_i.idx_at_fill) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = satq_pkg::RD_IDX;
        end else if (sts_i.act == satq_pkg::ACT_CLEAR) begin
          cmd_o.resp_load = 1'b1;
          cmd_o.resp_code = satq_pkg::ST_NOT_FOUND;
        end else if (sts_i.full) begin
          cmd_o.resp_load = 1'b1;
          cmd_o.resp_code = satq_pkg::ST_SET_FULL;
        end else begin
          cmd_o.idx_op = satq_pkg::IDX_FILL;
        end
      end
      satq_pkg::S_FIND_CHK: begin
        if (!sts_i.id_match) begin
          cmd_o.idx_op = satq_pkg::IDX_INC;
        end
      end
      satq_pkg::S_SHIFT_RD: begin
        if (sts_i.next_lt_fill) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = satq_pkg::RD_NEXT;
        end else begin
          cmd_o.fill_op = satq_pkg::FILL_DEC;
          if (sts_i.act == satq_pkg::ACT_CLEAR) begin
            cmd_o.resp_load = 1'b1;
            cmd_o.resp_code = satq_pkg::ST_CLEARED;
          end else begin
            cmd_o.idx_op = satq_pkg::IDX_FILL_M1;
          end
        end
      end
      satq_pkg::S_SHIFT_WR: begin
        cmd_o.wr_sel = satq_pkg::WR_SHIFT;
        cmd_o.idx_op = satq_pkg::IDX_INC;
      end
      satq_pkg::S_INS_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_sel    = satq_pkg::WR_NEW;
          cmd_o.fill_op   = satq_pkg::FILL_INC;
          cmd_o.resp_load = 1'b1;
          cmd_o.resp_code = satq_pkg::ST_SET_OK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = satq_pkg::RD_PREV;
        end
      end
      satq_pkg::S_INS_CHK: begin
        if (sts_i.due_gt) begin
          cmd_o.wr_sel = satq_pkg::WR_SHIFT;
          cmd_o.idx_op = satq_pkg::IDX_DEC;
        end else begin
          cmd_o.wr_sel    = satq_pkg::WR_NEW;
          cmd_o.fill_op   = satq_pkg::FILL_INC;
          cmd_o.resp_load = 1'b1;
          cmd_o.resp_code = satq_pkg::ST_SET_OK;
        end
      end
      satq_pkg::S_RESP: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_src  = satq_pkg::OUT_RESP;
        cmd_o.out_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/satq_dp.sv -----
module satq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    in_act_i,
  input  logic [satq_pkg::ENTRY_W-1:0]  in_data_i,  // {due_tick, alarm_id}
  input  satq_pkg::cmd_t                cmd_i,
  output satq_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    out_status_o,
  output logic [satq_pkg::ID_W-1:0]     out_id_o,
  output logic [satq_pkg::TICK_W-1:0]   out_tick_o,
  output logic                          out_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = satq_pkg::ID_W;
  localparam int unsigned TW = satq_pkg::TICK_W;
  localparam int unsigned EW = satq_pkg::ENTRY_W;
  localparam int unsigned PW = satq_pkg::POP_W;

  logic [TW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [PW-1:0] pops_q, pops_d;
  logic          pend_vld_q, pend_vld_d;
  logic [IW-1:0] pend_id_q;
  logic [1:0]    act_q;
  logic [IW-1:0] id_q;
  logic [TW-1:0] due_q;
  logic [2:0]    resp_q;

  logic          out_vld_q;
  logic [2:0]    out_status_q;
  logic [IW-1:0] out_id_q;
  logic [TW-1:0] out_tick_q;
  logic          out_last_q;

  logic [CW-1:0] rd_lidx;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data, rd_data;
  logic [TW-1:0] rd_due;
  logic [IW-1:0] rd_id;
  logic [CW:0]   idx_p1;
  logic          out_free;

  // logical slot -> RAM address on the circular buffer (sum stays below 2*DEPTH)
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(lidx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign idx_p1 = (CW+1)'(idx_q) + (CW+1)'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      satq_pkg::RD_HEAD: rd_lidx = '0;
      satq_pkg::RD_NEXT: rd_lidx = idx_p1[CW-1:0];
      satq_pkg::RD_PREV: rd_lidx = idx_q - CW'(1);
      default:           rd_lidx = idx_q;
    endcase
  end

  assign rd_addr = phys(head_q, rd_lidx);
  assign wr_addr = phys(head_q, idx_q);
  assign wr_en   = (cmd_i.wr_sel != satq_pkg::WR_NONE);
  assign wr_data = (cmd_i.wr_sel == satq_pkg::WR_NEW) ? {due_q, id_q} : rd_data;

  satq_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_due = rd_data[EW-1:IW];
  assign rd_id  = rd_data[IW-1:0];

  assign out_free = !out_vld_q || out_ready_i;

  // status
  assign sts_o.act          = satq_pkg::action_e'(act_q);
  assign sts_o.due_ok       = (fill_q != '0) && (pops_q < PW'(satq_pkg::MAX_FIRE))
                              && (rd_due <= cnt_q);
  assign sts_o.idx_at_fill  = (idx_q == fill_q);
  assign sts_o.next_lt_fill = (idx_p1 < (CW+1)'(fill_q));
  assign sts_o.idx_zero     = (idx_q == '0);
  assign sts_o.full         = (fill_q == CW'(DEPTH));
  assign sts_o.id_match     = (rd_id == id_q);
  assign sts_o.due_gt       = (rd_due > due_q);
  assign sts_o.pend_vld     = pend_vld_q;
  assign sts_o.out_free     = out_free;

  always_comb begin
    cnt_d      = cnt_q;
    head_d     = head_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    pops_d     = pops_q;
    pend_vld_d = pend_vld_q;

    if (cmd_i.tick_inc) begin
      cnt_d = cnt_q + TW'(1);
    end

    case (cmd_i.idx_op)
      satq_pkg::IDX_INC:     idx_d = idx_q + CW'(1);
      satq_pkg::IDX_DEC:     idx_d = idx_q - CW'(1);
      satq_pkg::IDX_FILL:    idx_d = fill_q;
      satq_pkg::IDX_FILL_M1: idx_d = fill_q - CW'(1);
      default:               idx_d = idx_q;
    endcase

    case (cmd_i.fill_op)
      satq_pkg::FILL_INC: fill_d = fill_q + CW'(1);
      satq_pkg::FILL_DEC: fill_d = fill_q - CW'(1);
      default:            fill_d = fill_q;
    endcase

    if (cmd_i.load_item) begin
      idx_d      = '0;
      pops_d     = '0;
      pend_vld_d = 1'b0;
    end

    // head alarm leaves by moving the head pointer
    if (cmd_i.pop) begin
      head_d     = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      fill_d     = fill_q - CW'(1);
      pops_d     = pops_q + PW'(1);
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_q     <= '0;
      fill_q     <= '0;
      idx_q      <= '0;
      pops_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      idx_q      <= idx_d;
      pops_q     <= pops_d;
      pend_vld_q <= pend_vld_d;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q <= in_act_i;
      id_q  <= in_data_i[IW-1:0];
      due_q <= in_data_i[EW-1:IW];
    end
    if (cmd_i.pop) begin
      pend_id_q <= rd_id;
    end
    if (cmd_i.resp_load) begin
      resp_q <= cmd_i.resp_code;
    end
    if (cmd_i.out_load) begin
      out_tick_q <= cnt_q;
      out_last_q <= cmd_i.out_last;
      if (cmd_i.out_src == satq_pkg::OUT_PEND) begin
        out_status_q <= satq_pkg::ST_FIRED;
        out_id_q     <= pend_id_q;
      end else begin
        out_status_q <= resp_q;
        out_id_q     <= id_q;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_tick_o   = out_tick_q;
  assign out_last_o   = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("queue fill above depth");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over a waiting result");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && cmd_i.rd_en))
    else $error("RAM read and write in the same cycle");

  a_pop_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (pops_q <= PW'(satq_pkg::MAX_FIRE)) && (fill_q == $past(fill_q) - CW'(1)))
    else $error("pop count or fill slipped");

endmodule

// ----- sim/tb_sorted_alarm_timer_queue.sv -----
module tb_sorted_alarm_timer_queue;

  localparam int unsigned QUEUE_SLOTS  = 16;
  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned TAIL_CYCLES  = 250;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;  // dropped by the block, no result

  // one result as seen on the master side
  typedef struct packed {
    satq_pkg::status_e status;
    logic [3:0]        id;
    logic [31:0]       now;
    logic              last;
  } report_t;

  // directed stimulus row; typed < 0: predictor decides, 0: no result,
  // 1: the single result below
  typedef struct packed {
    logic [1:0]        act;
    logic [3:0]        id;
    logic [31:0]       due;
    int                typed;
    satq_pkg::status_e st;
    logic [3:0]        exp_id;
    logic [31:0]       now;
  } dir_row_t;

  localparam int unsigned N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{satq_pkg::ACT_TICK,  4'd0,  32'd0,         0,  satq_pkg::ST_FIRED,     4'd0,  32'd1},
    '{satq_pkg::ACT_CLEAR, 4'd5,  32'd0,         1,  satq_pkg::ST_NOT_FOUND, 4'd5,  32'd1},
    '{satq_pkg::ACT_SET,   4'd0,  32'd0,         1,  satq_pkg::ST_SET_OK,    4'd0,  32'd1},
    '{satq_pkg::ACT_SET,   4'd15, 32'd2,         1,  satq_pkg::ST_SET_OK,    4'd15, 32'd1},
    // ties with id 15
    '{satq_pkg::ACT_SET,   4'd3,  32'd2,         1,  satq_pkg::ST_SET_OK,    4'd3,  32'd1},
    '{satq_pkg::ACT_SET,   4'd7,  32'hFFFF_FFFF, 1,  satq_pkg::ST_SET_OK,    4'd7,  32'd1},
    // replaces id 7
    '{satq_pkg::ACT_SET,   4'd7,  32'd5,         1,  satq_pkg::ST_SET_OK,    4'd7,  32'd1},
    '{satq_pkg::ACT_SET,   4'd9,  32'd0,         -1, satq_pkg::ST_FIRED,     4'd0,  32'd0},
    // four fire
    '{satq_pkg::ACT_TICK,  4'd0,  32'd0,         -1, satq_pkg::ST_FIRED,     4'd0,  32'd0},
    '{satq_pkg::ACT_CLEAR, 4'd7,  32'd0,         1,  satq_pkg::ST_CLEARED,   4'd7,  32'd2},
    '{satq_pkg::ACT_CLEAR, 4'd7,  32'd0,         1,  satq_pkg::ST_NOT_FOUND, 4'd7,  32'd2},
    '{ACT_UNUSED,          4'd9,  32'd123,       0,  satq_pkg::ST_FIRED,     4'd0,  32'd0},
    '{satq_pkg::ACT_SET,   4'd12, 32'd3,         1,  satq_pkg::ST_SET_OK,    4'd12, 32'd2},
    '{satq_pkg::ACT_SET,   4'd6,  32'd3,         -1, satq_pkg::ST_FIRED,     4'd0,  32'd0},
    '{satq_pkg::ACT_CLEAR, 4'd12, 32'd0,         1,  satq_pkg::ST_CLEARED,   4'd12, 32'd2},
    '{satq_pkg::ACT_TICK,  4'd0,  32'd0,         1,  satq_pkg::ST_FIRED,     4'd6,  32'd3},
    '{satq_pkg::ACT_TICK,  4'd0,  32'd0,         0,  satq_pkg::ST_FIRED,     4'd0,  32'd4},
    '{satq_pkg::ACT_SET,   4'd10, 32'hFFFF_FFFF, 1,  satq_pkg::ST_SET_OK,    4'd10, 32'd4},
    '{satq_pkg::ACT_SET,   4'd0,  32'h8000_0000, -1, satq_pkg::ST_FIRED,     4'd0,  32'd0},
    '{satq_pkg::ACT_TICK,  4'd0,  32'd0,         0,  satq_pkg::ST_FIRED,     4'd0,  32'd5},
    '{satq_pkg::ACT_CLEAR, 4'd0,  32'd0,         1,  satq_pkg::ST_CLEARED,   4'd0,  32'd5}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [3:0] alarm_id, [35:4] due_tick, [39:36] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [3:0] result_id, [35:4] now_tick, [39:36] zero
  logic [2:0]  m_axis_tuser;        // [2:0] status
  logic        m_axis_tlast;

  sorted_alarm_timer_queue #(
    .DEPTH(QUEUE_SLOTS)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("sorted_alarm_timer_queue: mismatch");
    $finish;
  end

  // shadow alarm queue, sorted by due tick
  logic [31:0] tick_now = '0;
  logic [31:0] q_due [QUEUE_SLOTS];
  logic [3:0]  q_id  [QUEUE_SLOTS];
  int unsigned q_fill = 0;

  report_t     fresh[$];          // results of the item just accepted
  report_t     timer_reports[$];  // results still to come from the block
  int unsigned fault_count = 0;
  int unsigned snd_idle_pct = 19;
  int unsigned rcv_idle_pct = 73;

  function automatic int slot_of(input logic [3:0] id);
    for (int i = 0; i < int'(q_fill); i++) begin
      if (q_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < int'(q_fill); i++) begin
      q_due[i] = q_due[i+1];
      q_id[i]  = q_id[i+1];
    end
    q_fill--;
  endfunction

  // advance the shadow queue by one item, leave its results in fresh
  function automatic void step_alarms(input logic [1:0] act, input logic [3:0] id,
                                      input logic [31:0] due);
    int pos;
    int ins;
    report_t r;
    fresh.delete();
    case (act)
      satq_pkg::ACT_TICK: begin
        tick_now = tick_now + 32'd1;
        while (q_fill > 0 && fresh.size() < satq_pkg::MAX_FIRE && q_due[0] <= tick_now) begin
          r = '{status: satq_pkg::ST_FIRED, id: q_id[0], now: tick_now, last: 1'b0};
          fresh.push_back(r);
          drop_slot(0);
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      end
      satq_pkg::ACT_SET: begin
        pos = slot_of(id);
        if (pos < 0 && q_fill >= QUEUE_SLOTS) begin
          r = '{status: satq_pkg::ST_SET_FULL, id: id, now: tick_now, last: 1'b1};
        end else begin
          if (pos >= 0) drop_slot(pos);
          ins = 0;
          while (ins < int'(q_fill) && q_due[ins] <= due) ins++;
          for (int i = int'(q_fill); i > ins; i--) begin
            q_due[i] = q_due[i-1];
            q_id[i]  = q_id[i-1];
          end
          q_due[ins] = due;
          q_id[ins]  = id;
          q_fill++;
          r = '{status: satq_pkg::ST_SET_OK, id: id, now: tick_now, last: 1'b1};
        end
        fresh.push_back(r);
      end
      satq_pkg::ACT_CLEAR: begin
        pos = slot_of(id);
        if (pos >= 0) begin
          drop_slot(pos);
          r = '{status: satq_pkg::ST_CLEARED, id: id, now: tick_now, last: 1'b1};
        end else begin
          r = '{status: satq_pkg::ST_NOT_FOUND, id: id, now: tick_now, last: 1'b1};
        end
        fresh.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // one slave-side transfer; typed >= 0 overrides the predicted results
  task automatic send_item(input logic [1:0] act, input logic [3:0] id,
                           input logic [31:0] due, input int typed, input report_t fixed);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, due, id};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    step_alarms(act, id, due);
    if (typed < 0) begin
      foreach (fresh[i]) timer_reports.push_back(fresh[i]);
    end else if (typed == 1) begin
      timer_reports.push_back(fixed);
    end
  endtask

  // hold the sender until every pending result is out, then change pacing
  task automatic retune_pace(input int unsigned snd, input int unsigned rcv);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (timer_reports.size() != 0);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // random set/clear/tick/unused-action mix; clears mostly aim at queued ids
  task automatic random_item(inout int unsigned counted);
    int unsigned pick;
    logic [1:0]  act;
    logic [3:0]  id;
    logic [31:0] due;
    pick = $urandom_range(99);
    id   = 4'($urandom_range(15));
    if ($urandom_range(9) == 0) due = $urandom();
    else due = tick_now + 32'($urandom_range(12)) - 32'd2;
    if (pick < 40) act = satq_pkg::ACT_TICK;
    else if (pick < 75) act = satq_pkg::ACT_SET;
    else if (pick < 96) act = satq_pkg::ACT_CLEAR;
    else act = ACT_UNUSED;
    if (act == satq_pkg::ACT_CLEAR && q_fill > 0 && $urandom_range(3) != 0)
      id = q_id[$urandom_range(q_fill - 1)];
    send_item(act, id, due, -1, '0);
    counted++;
  endtask

  // fill every slot with alarms due within two ticks, then tick them out
  task automatic fill_and_fire(inout int unsigned counted);
    int unsigned order [16];
    int unsigned j;
    int unsigned tmp;
    logic        all_next;
    all_next = ($urandom_range(1) == 0);
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 16; i++) begin
      send_item(satq_pkg::ACT_SET, 4'(order[i]),
                tick_now + (all_next ? 32'd1 : 32'($urandom_range(1, 2))), -1, '0);
    end
    for (int i = 0; i < 3; i++) begin
      send_item(satq_pkg::ACT_TICK, 4'($urandom_range(15)), $urandom(), -1, '0);
    end
    counted += 19;
  endtask

  // master side: check each transfer, then pick next tready
  always @(posedge clk_i) begin : rx_check
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (timer_reports.size() == 0) begin
        $display("%0t: unexpected result status %0d id %0d now %0d last %0d, expected none",
                 $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast);
        fault_count++;
      end else begin
        want = timer_reports.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[3:0] !== want.id ||
            m_axis_tdata[35:4] !== want.now || m_axis_tlast !== want.last ||
            m_axis_tdata[39:36] !== 4'b0) begin
          $display("%0t: expected status %0d id %0d now %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.status, want.id, want.now, want.last,
                   m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast);
          fault_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin : stimulus
    dir_row_t    row;
    report_t     fixed;
    int unsigned counted;
    int unsigned waited;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIR; k++) begin
      row   = DIR_ROWS[k];
      fixed = '{status: row.st, id: row.exp_id, now: row.now, last: 1'b1};
      send_item(row.act, row.id, row.due, row.typed, fixed);
    end
    retune_pace(19, 73);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= RANDOM_ITEMS / 3 && snd_idle_pct == 19) retune_pace(73, 19);
      if (counted >= 2 * RANDOM_ITEMS / 3 && snd_idle_pct == 73) retune_pace(0, 0);
      if ($urandom_range(39) == 0) fill_and_fire(counted);
      else random_item(counted);
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (timer_reports.size() != 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && timer_reports.size() == 0) begin
      $display("sorted_alarm_timer_queue: match");
    end else begin
      $display("sorted_alarm_timer_queue: mismatch");
    end
    $finish;
  end

endmodule

// ----- sorted_alarm_timer_queue.f -----
rtl/core/satq_pkg.sv
rtl/core/satq_ram.sv
rtl/core/satq_ctrl.sv
rtl/core/satq_dp.sv
rtl/core/sorted_alarm_timer_queue.sv
sim/tb_sorted_alarm_timer_queue.sv
